[src/coo_spmv_pkg.sv]
// Package for the coordinate-form sparse matrix times vector row reducer.
// Holds the request and result types, operation codes and fixed constants.
// No dependencies.
package coo_spmv_pkg;

  // Operation carried by a request.
  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_NONZERO = 1'b1
  } op_t;

  // One input request.
  typedef struct packed {
    op_t                op;
    logic        [11:0] column;
    logic        [15:0] row;
    logic signed [31:0] value;
    logic               last;
  } in_req_t;

  // One finished row.
  typedef struct packed {
    logic        [15:0] out_row;
    logic signed [47:0] row_sum;
    logic               end_of_run;
  } out_rsp_t;

  // Saturation bounds of the Q32.16 row sum.
  localparam logic signed [47:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SUM_MIN = 48'sh8000_0000_0000;

  // Rounding offset for the Q32.32 to Q32.16 product conversion.
  localparam logic signed [63:0] ROUND_HALF = 64'sd32768;

  // Result queue geometry. A request may only enter while the queue holds
  // at most FILL_LIMIT entries: three requests in flight plus the new one
  // can add at most eight results.
  localparam int unsigned    RQ_DEPTH   = 16;
  localparam int unsigned    RQ_AW      = 4;
  localparam logic [RQ_AW:0] FILL_LIMIT = 5'd8;

endpackage

[src/coo_spmv_row_reduction.sv]
// Top level of the coordinate-form sparse matrix times vector row reducer.
// Uses coo_spmv_pkg for the request/result types and constants.
//
// Usage:
//   in_valid/in_ready/in_data carry requests. A load request (op = OP_LOAD)
//   writes one Q16.16 element of the dense vector store. A nonzero request
//   (op = OP_NONZERO) multiplies its value by the stored element at its
//   column and adds the rounded product into the open row sum. A change of
//   row emits the finished (row, sum) pair; a nonzero marked last flushes
//   its own row as well, so one request yields zero, one or two results.
//   out_valid/out_ready/out_data deliver results; end_of_run marks the
//   final result caused by one request.
//   Throughput is one request per cycle while in_ready is high, set by the
//   single-port vector store and the multiply pipeline. A result passes the
//   s1, s2 and s3 registers into the result queue and, if it was empty, is
//   presented on the cycle after the write. When the receiver stalls,
//   results collect in a 16-entry queue; in_ready drops above eight entries.
//   Reset clears the pipeline, the open row and the queue. The vector store
//   has no reset and no clearing pass: load each element before use.
module coo_spmv_row_reduction #(
  parameter int VECTOR_DEPTH = 4096,
  parameter int ROW_COUNT    = 65536
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  coo_spmv_pkg::in_req_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output coo_spmv_pkg::out_rsp_t out_data
);

  localparam int ADDR_W = $clog2(VECTOR_DEPTH);

  // Vector store.
  logic        [31:0]       vec_mem [VECTOR_DEPTH];
  logic        [31:0]       rd_data_r;
  logic        [ADDR_W-1:0] vec_addr;
  logic                     in_accept;
  logic                     col_ok;
  logic                     row_ok;

  // Pipeline stage registers.
  logic                     s1_vld_r, s2_vld_r, s3_vld_r;
  logic                     s1_row_ok_r, s2_row_ok_r, s3_row_ok_r;
  logic                     s1_last_r, s2_last_r, s3_last_r;
  logic                     s1_col_ok_r;
  logic        [15:0]       s1_row_r, s2_row_r, s3_row_r;
  logic signed [31:0]       s1_value_r;
  logic signed [31:0]       elem;
  logic signed [63:0]       mul_res;
  logic signed [63:0]       s2_prod_r;
  logic signed [63:0]       prod_rnd;
  logic signed [47:0]       s3_prod_r;

  // Row accumulator state.
  logic        [15:0]       cur_row_r, cur_row_nxt;
  logic signed [47:0]       sum_r, sum_nxt;
  logic                     row_open_r, row_open_nxt;
  logic signed [48:0]       acc_wide;
  logic signed [47:0]       acc_sat;
  logic        [15:0]       mid_row;
  logic signed [47:0]       mid_sum;
  logic                     mid_open;
  logic                     emit_change;
  logic                     emit_last;

  // Result queue.
  coo_spmv_pkg::out_rsp_t   rq_mem [coo_spmv_pkg::RQ_DEPTH];
  logic [coo_spmv_pkg::RQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [coo_spmv_pkg::RQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [coo_spmv_pkg::RQ_AW-1:0] wr_ptr_p1;
  logic [coo_spmv_pkg::RQ_AW:0]   cnt_r, cnt_nxt;
  logic [1:0]                     push_cnt;
  logic                           pop;
  coo_spmv_pkg::out_rsp_t         push_a;
  coo_spmv_pkg::out_rsp_t         push_b;

  // Request acceptance and range checks.
  assign in_ready  = (cnt_r <= coo_spmv_pkg::FILL_LIMIT);
  assign in_accept = in_valid && in_ready;
  assign col_ok    = (32'(in_data.column) < VECTOR_DEPTH);
  assign row_ok    = (32'(in_data.row) < ROW_COUNT);
  assign vec_addr  = ADDR_W'(in_data.column);

  // Vector store: loads write at accept, nonzeros read into the rd_data_r register.
  always_ff @(posedge clk) begin
    if (in_accept && col_ok && (in_data.op == coo_spmv_pkg::OP_LOAD)) begin
      vec_mem[vec_addr] <= in_data.value;
    end
    if (in_accept && (in_data.op == coo_spmv_pkg::OP_NONZERO)) begin
      rd_data_r <= vec_mem[vec_addr];
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_accept && (in_data.op == coo_spmv_pkg::OP_NONZERO);
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  // Multiply the matrix value by the stored element; columns past the store read zero.
  assign elem    = s1_col_ok_r ? $signed(rd_data_r) : 32'sd0;
  assign mul_res = s1_value_r * elem;

  // Round half up to Q32.16; the magnitude stays within 48 bits.
  assign prod_rnd = s2_prod_r + coo_spmv_pkg::ROUND_HALF;

  // Stage payload registers.
  always_ff @(posedge clk) begin
    s1_row_ok_r <= row_ok;
    s1_col_ok_r <= col_ok;
    s1_last_r   <= in_data.last;
    s1_row_r    <= in_data.row;
    s1_value_r  <= in_data.value;
    s2_row_ok_r <= s1_row_ok_r;
    s2_last_r   <= s1_last_r;
    s2_row_r    <= s1_row_r;
    s2_prod_r   <= mul_res;
    s3_row_ok_r <= s2_row_ok_r;
    s3_last_r   <= s2_last_r;
    s3_row_r    <= s2_row_r;
    s3_prod_r   <= prod_rnd[63:16];
  end

  // Saturating accumulate into the open row.
  assign acc_wide = {sum_r[47], sum_r} + {s3_prod_r[47], s3_prod_r};
  always_comb begin
    if (acc_wide[48] != acc_wide[47]) begin
      acc_sat = acc_wide[48] ? coo_spmv_pkg::SUM_MIN : coo_spmv_pkg::SUM_MAX;
    end else begin
      acc_sat = acc_wide[47:0];
    end
  end

  // Row change and flush decisions, then the next accumulator state.
  always_comb begin
    emit_change = 1'b0;
    mid_row     = cur_row_r;
    mid_sum     = sum_r;
    mid_open    = row_open_r;
    if (s3_vld_r && s3_row_ok_r) begin
      emit_change = row_open_r && (s3_row_r != cur_row_r);
      mid_open    = 1'b1;
      if (!row_open_r || emit_change) begin
        mid_row = s3_row_r;
        mid_sum = s3_prod_r;
      end else begin
        mid_sum = acc_sat;
      end
    end
    emit_last    = s3_vld_r && s3_last_r && mid_open;
    cur_row_nxt  = mid_row;
    sum_nxt      = emit_last ? 48'sd0 : mid_sum;
    row_open_nxt = mid_open && !emit_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r  <= '0;
      sum_r      <= '0;
      row_open_r <= 1'b0;
    end else begin
      cur_row_r  <= cur_row_nxt;
      sum_r      <= sum_nxt;
      row_open_r <= row_open_nxt;
    end
  end

  // Results to push: the closed row first, then the flushed row.
  always_comb begin
    push_b.out_row    = mid_row;
    push_b.row_sum    = mid_sum;
    push_b.end_of_run = 1'b1;
    if (emit_change) begin
      push_a.out_row    = cur_row_r;
      push_a.row_sum    = sum_r;
      push_a.end_of_run = !emit_last;
    end else begin
      push_a = push_b;
    end
    push_cnt = 2'(emit_change) + 2'(emit_last);
  end

  // Result queue storage.
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      rq_mem[wr_ptr_r] <= push_a;
    end
    if (push_cnt == 2'd2) begin
      rq_mem[wr_ptr_p1] <= push_b;
    end
  end

  // Result queue pointers and fill count.
  assign out_valid = (cnt_r != '0);
  assign out_data  = rq_mem[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + coo_spmv_pkg::RQ_AW'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + coo_spmv_pkg::RQ_AW'(pop);
    cnt_nxt    = cnt_r + (coo_spmv_pkg::RQ_AW + 1)'(push_cnt)
               - (coo_spmv_pkg::RQ_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // The queue never overflows, even with two pushes in one cycle.
  a_rq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt != 2'd0) |->
      ((32'(cnt_r) + 32'(push_cnt)) <= coo_spmv_pkg::RQ_DEPTH))
    else $error("result queue overflow");

  // A nonzero marked last always leaves no row open.
  a_last_closes_row: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_vld_r && s3_last_r) |=> !row_open_r)
    else $error("row still open after last nonzero");

  // A row change always pushes the closed row.
  a_change_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    emit_change |-> (push_cnt != 2'd0) && (push_a.out_row == cur_row_r))
    else $error("row change without a pushed result");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Testbench for coo_spmv_row_reduction: directed and random request streams checked
// against a row reduction predictor kept inside the bench.
// Depends on coo_spmv_pkg and the coo_spmv_row_reduction RTL.
module tb;

  localparam int     CLK_HALF     = 5;
  localparam int     RESET_CYCLES = 7;
  localparam int     RANDOM_ITEMS = 630;
  localparam int     PAUSE_AFTER  = 300;
  localparam int     TAIL_CYCLES  = 12;
  localparam int     CYCLE_LIMIT  = 200000;
  localparam int     PRINT_LIMIT  = 100;
  localparam longint ACC_MAX      = 64'sd140737488355327;
  localparam longint ACC_MIN      = -ACC_MAX - 1;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  coo_spmv_pkg::in_req_t  in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  coo_spmv_pkg::out_rsp_t out_data;

  // Predictor state: an image of the vector store and the open row sum.
  logic signed [31:0] vec_image [0:4095];
  logic        [15:0] open_row   = '0;
  longint             row_acc    = 0;
  bit                 row_active = 1'b0;

  // Finished rows still to come out of the block, oldest first.
  coo_spmv_pkg::out_rsp_t pending_rows[$];
  coo_spmv_pkg::out_rsp_t head_row;

  // Columns already loaded, so nonzeros only read written elements.
  int loaded_cols[$];
  bit col_loaded [0:4095];

  int error_count = 0;
  int cycle_count = 0;
  int items_sent  = 0;
  bit calm        = 1'b0;

  coo_spmv_row_reduction dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #CLK_HALF clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver stalls at random, except during the calm stretch.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 12);
  end

  task automatic report_mismatch(input string msg);
    if (error_count < PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // Apply one accepted request to the predictor and queue the rows it closes.
  function automatic void reduce_request(input coo_spmv_pkg::in_req_t req);
    logic signed [31:0]     elem;
    logic signed [31:0]     coeff;
    longint                 prod;
    longint                 sum;
    coo_spmv_pkg::out_rsp_t done [2];
    int                     n;
    n = 0;
    if (req.op == coo_spmv_pkg::OP_LOAD) begin
      vec_image[req.column] = req.value;
    end else begin
      elem  = vec_image[req.column];
      coeff = req.value;
      // Exact Q32.32 product, rounded half up to Q32.16.
      prod  = (longint'(coeff) * longint'(elem) + 64'sd32768) >>> 16;
      // A change of row closes the open one.
      if (row_active && req.row != open_row) begin
        done[n].out_row    = open_row;
        done[n].row_sum    = row_acc[47:0];
        done[n].end_of_run = 1'b0;
        n++;
        row_active = 1'b0;
      end
      if (!row_active) begin
        open_row   = req.row;
        row_acc    = prod;
        row_active = 1'b1;
      end else begin
        sum = row_acc + prod;
        if (sum > ACC_MAX) begin
          sum = ACC_MAX;
        end else if (sum < ACC_MIN) begin
          sum = ACC_MIN;
        end
        row_acc = sum;
      end
      // The final nonzero flushes its own row.
      if (req.last && row_active) begin
        done[n].out_row    = open_row;
        done[n].row_sum    = row_acc[47:0];
        done[n].end_of_run = 1'b0;
        n++;
        row_active = 1'b0;
        row_acc    = 0;
      end
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) begin
        done[i].end_of_run = 1'b1;
      end
      pending_rows.push_back(done[i]);
    end
  endfunction

  // Check each result against the oldest pending row.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_rows.size() == 0) begin
        report_mismatch($sformatf("unexpected result row %0d sum %0d eor %0b",
                                  out_data.out_row, out_data.row_sum, out_data.end_of_run));
      end else begin
        head_row = pending_rows.pop_front();
        if (out_data.out_row !== head_row.out_row) begin
          report_mismatch($sformatf("out_row %0d, expected %0d",
                                    out_data.out_row, head_row.out_row));
        end
        if (out_data.row_sum !== head_row.row_sum) begin
          report_mismatch($sformatf("row %0d row_sum %0d, expected %0d",
                                    head_row.out_row, out_data.row_sum, head_row.row_sum));
        end
        if (out_data.end_of_run !== head_row.end_of_run) begin
          report_mismatch($sformatf("row %0d end_of_run %0b, expected %0b",
                                    head_row.out_row, out_data.end_of_run,
                                    head_row.end_of_run));
        end
      end
    end
  end

  // Send one request; valid stays high after acceptance unless the next call idles.
  task automatic send_req(input coo_spmv_pkg::in_req_t req);
    while (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    reduce_request(req);
    items_sent++;
  endtask

  task automatic send_load(input logic [11:0] col, input logic [31:0] val, input logic last);
    coo_spmv_pkg::in_req_t req;
    req.op     = coo_spmv_pkg::OP_LOAD;
    req.column = col;
    req.row    = 16'($urandom());
    req.value  = val;
    req.last   = last;
    if (!col_loaded[col]) begin
      col_loaded[col] = 1'b1;
      loaded_cols.push_back(col);
    end
    send_req(req);
  endtask

  task automatic send_nonzero(input logic [15:0] row, input logic [11:0] col,
                              input logic [31:0] val, input logic last);
    coo_spmv_pkg::in_req_t req;
    req.op     = coo_spmv_pkg::OP_NONZERO;
    req.column = col;
    req.row    = row;
    req.value  = val;
    req.last   = last;
    send_req(req);
  endtask

  // Stop sending and wait until every pending row has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Mostly small Q16.16 values, with full-range and extreme ones mixed in.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
      6, 7:             return $urandom();
      8: begin
        case ($urandom_range(3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default:          return ($urandom_range(64) - 32) << 16;
    endcase
  endfunction

  function automatic logic [11:0] pick_loaded_col();
    return 12'(loaded_cols[$urandom_range(loaded_cols.size() - 1)]);
  endfunction

  // Vector loads at both ends of the store, extreme values, and a load marked last.
  task automatic test_vector_loads();
    send_load(12'd0, 32'h0001_0000, 1'b0);
    send_load(12'hFFF, 32'h8000_0000, 1'b0);
    send_load(12'hAAA, 32'h7FFF_FFFF, 1'b0);
    send_load(12'h555, 32'hFFFF_FFFF, 1'b0);
    send_load(12'd1, 32'h0000_8000, 1'b0);
    // Last on a load is ignored and nothing is open yet.
    send_load(12'd2, 32'h0002_0000, 1'b1);
  endtask

  // Row changes, rounding at the half point, last flushes, two results from one request.
  task automatic test_row_boundaries();
    send_nonzero(16'd0, 12'd0, 32'h7FFF_FFFF, 1'b0);
    send_nonzero(16'd0, 12'd1, 32'h0000_0001, 1'b0);
    send_nonzero(16'd0, 12'd1, 32'hFFFF_FFFF, 1'b0);
    send_nonzero(16'hFFFF, 12'hAAA, 32'h8000_0000, 1'b0);
    send_nonzero(16'hFFFF, 12'h555, 32'h1234_5678, 1'b1);
    send_nonzero(16'd9, 12'd0, 32'h0003_0000, 1'b0);
    send_nonzero(16'd10, 12'd1, 32'hFFFE_0000, 1'b1);
  endtask

  // Largest products drive the row sum into both saturation bounds.
  task automatic test_saturation();
    repeat (3) send_nonzero(16'd100, 12'hFFF, 32'h8000_0000, 1'b0);
    send_nonzero(16'd200, 12'hFFF, 32'h7FFF_FFFF, 1'b0);
    send_nonzero(16'd200, 12'hFFF, 32'h7FFF_FFFF, 1'b0);
    send_nonzero(16'd200, 12'hFFF, 32'h7FFF_FFFF, 1'b1);
  endtask

  // A row that comes back after another row is emitted again on its own.
  task automatic test_unsorted_rows();
    send_nonzero(16'd5, 12'd0, 32'h0001_8000, 1'b0);
    send_nonzero(16'd7, 12'd2, 32'hFFFF_0000, 1'b0);
    send_nonzero(16'd5, 12'hAAA, 32'h0000_0100, 1'b1);
  endtask

  // Random matrices: vector refills, then rows in order with some noise.
  task automatic test_random_stream();
    int          target;
    int          burst;
    int          nrows;
    int          nnz;
    bit          paused;
    bit          last;
    logic [15:0] row;
    target = items_sent + RANDOM_ITEMS;
    paused = 1'b0;
    row    = 16'($urandom_range(65535));
    while (items_sent < target) begin
      burst = $urandom_range(1, 8);
      repeat (burst) send_load(12'($urandom_range(4095)), pick_value(), 1'($urandom_range(1)));
      nrows = $urandom_range(1, 6);
      for (int r = 0; r < nrows; r++) begin
        nnz = $urandom_range(1, 5);
        for (int k = 0; k < nnz; k++) begin
          // Occasional load in the middle of a matrix.
          if ($urandom_range(99) < 5) begin
            send_load(12'($urandom_range(4095)), pick_value(), 1'b0);
          end
          // Last on the final nonzero, and now and then too early.
          last = (r == nrows - 1 && k == nnz - 1) || ($urandom_range(99) < 3);
          send_nonzero(row, pick_loaded_col(), pick_value(), last);
        end
        // Mostly ascending rows; a jump anywhere breaks the ordering.
        if ($urandom_range(99) < 8) begin
          row = 16'($urandom_range(65535));
        end else begin
          row = row + 16'($urandom_range(1, 4));
        end
      end
      if (!paused && items_sent > PAUSE_AFTER) begin
        wait_drained();
        paused = 1'b1;
      end
      calm = (items_sent > 420) && (items_sent < 540);
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_vector_loads();
    test_row_boundaries();
    test_saturation();
    test_unsorted_rows();
    test_random_stream();
    wait_drained();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
src/coo_spmv_pkg.sv
src/coo_spmv_row_reduction.sv
verif/tb.sv
